// File: rtl/floor_call_scheduler_top_defines.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies.
`ifndef FLOOR_CALL_SCHEDULER_TOP_DEFINES_SVH
`define FLOOR_CALL_SCHEDULER_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define FCS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define FCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/fcs_pkg.sv
// Types and constants for the floor call scheduler.
// No dependencies.
package fcs_pkg;

  localparam int unsigned TRAVEL_BITS = 12;
  localparam logic [TRAVEL_BITS-1:0] TRAVEL_MAX = '1;

  localparam logic [1:0] MODE_ARRIVAL = 2'd0;
  localparam logic [1:0] MODE_SCAN    = 2'd1;
  localparam logic [1:0] MODE_NEAREST = 2'd2;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_RUN = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic add_call;   // append the request floor
    logic run_init;   // clear marks and travel, latch start floor
    logic scan_start; // begin a search pass
    logic scan_step;  // examine one stored call
    logic serve;      // serve the chosen call and emit a result
    logic empty_out;  // emit the empty-run result
  } fcs_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic no_calls;
    logic scan_done;
    logic run_done;
  } fcs_stat_t;

endpackage

// File: rtl/floor_call_scheduler_top.sv
// Top level of the floor call scheduler: register port, controller, datapath.
// Depends on fcs_pkg, fcs_ctrl and fcs_datapath.
//
// Usage: raise start with req_type and call_floor while busy is low.
// An add (req_type 0) stores call_floor and gives no result;
// adds beyond MAX_CALLS are dropped. A run (req_type 1) serves every stored
// call in the order set by schedule_mode (APB register at address 0) and
// emits one result per call, each marked by done for a single cycle; the
// last carries is_last and total_travel. A run with no calls gives one
// result flagged empty_run by way of the ST_EMPTY state.
// Each served call takes one search pass over the store, which reads one
// stored call at a time through the single read port of the store; the
// SCAN mode may take a second pass. busy stays high over the whole run.
// Results cannot be stalled. Reset clears the call count, the car floor
// (to 0) and the mode; stored floors need no clearing.
// Write schedule_mode only while busy is low.
module floor_call_scheduler_top import fcs_pkg::*; #(
  parameter int unsigned MAX_CALLS  = 16,
  parameter int unsigned FLOOR_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [7:0]  call_floor,
  output logic        done,
  output logic [7:0]  served_floor,
  output logic [1:0]  direction,
  output logic [11:0] total_travel,
  output logic        is_last,
  output logic        empty_run
);

  logic [1:0] schedule_mode;
  fcs_cmd_t   cmd;
  fcs_stat_t  stat;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {30'd0, schedule_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst)
      schedule_mode <= MODE_ARRIVAL;
    else if (psel && penable && pwrite && paddr == 2'd0)
      schedule_mode <= pwdata[1:0];
  end

  fcs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .req_type(req_type),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  fcs_datapath #(.MAX_CALLS(MAX_CALLS), .FLOOR_BITS(FLOOR_BITS)) u_dp (
    .clk(clk), .rst(rst), .schedule_mode(schedule_mode), .call_floor(call_floor),
    .cmd(cmd), .stat(stat), .result_valid(done), .served_floor(served_floor),
    .direction(direction), .total_travel(total_travel), .is_last(is_last),
    .empty_run(empty_run)
  );

endmodule

// File: rtl/fcs_datapath.sv
// Datapath of the floor call scheduler: call store, search unit, car state.
// Depends on fcs_pkg and the assertion macro header.
`include "floor_call_scheduler_top_defines.svh"

module fcs_datapath import fcs_pkg::*; #(
  parameter int unsigned MAX_CALLS  = 16,
  parameter int unsigned FLOOR_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             schedule_mode,
  input  logic [7:0]             call_floor,
  input  fcs_cmd_t               cmd,
  output fcs_stat_t              stat,
  output logic                   result_valid,
  output logic [7:0]             served_floor,
  output logic [1:0]             direction,
  output logic [TRAVEL_BITS-1:0] total_travel,
  output logic                   is_last,
  output logic                   empty_run
);

  localparam int unsigned IDX_BITS = (MAX_CALLS > 1) ? $clog2(MAX_CALLS) : 1;
  localparam int unsigned CNT_BITS = $clog2(MAX_CALLS + 1);
  localparam int unsigned SUM_BITS = TRAVEL_BITS + FLOOR_BITS;

  logic [FLOOR_BITS-1:0] store [MAX_CALLS];
  logic [CNT_BITS-1:0]   call_total;
  logic [FLOOR_BITS-1:0] car_floor;
  logic [FLOOR_BITS-1:0] start_floor;
  logic [MAX_CALLS-1:0]  served_marks;
  logic [TRAVEL_BITS-1:0] travel_sum;
  logic [CNT_BITS-1:0]   served_cnt;
  logic [CNT_BITS-1:0]   scan_idx;
  logic [IDX_BITS-1:0]   best_idx;
  logic [FLOOR_BITS-1:0] best_floor;
  logic                  found;
  logic                  scan_phase;

  logic [FLOOR_BITS-1:0] cur_floor;
  logic [FLOOR_BITS-1:0] cand_dist;
  logic [FLOOR_BITS-1:0] best_dist;
  logic [FLOOR_BITS-1:0] move_dist;
  logic [SUM_BITS-1:0]   travel_add;
  logic [TRAVEL_BITS-1:0] travel_sat;
  logic                  take;
  logic                  scan_end;
  logic [IDX_BITS-1:0]   rd_idx;

  assign rd_idx    = scan_idx[IDX_BITS-1:0];
  assign cur_floor = store[rd_idx];
  assign cand_dist = (cur_floor > car_floor) ? cur_floor - car_floor : car_floor - cur_floor;
  assign best_dist = (best_floor > car_floor) ? best_floor - car_floor
                                              : car_floor - best_floor;
  assign move_dist = best_dist;
  assign travel_add = SUM_BITS'(travel_sum) + SUM_BITS'(move_dist);
  assign travel_sat = (travel_add > SUM_BITS'(TRAVEL_MAX)) ? TRAVEL_MAX
                                                           : travel_add[TRAVEL_BITS-1:0];

  // Second SCAN pass (downward) takes the largest remaining call.
  always_comb begin
    take = 1'b0;
    if (!served_marks[rd_idx]) begin
      case (schedule_mode)
        MODE_SCAN: begin
          if (!scan_phase)
            take = (cur_floor >= start_floor) && (!found || cur_floor < best_floor);
          else
            take = !found || cur_floor > best_floor;
        end
        MODE_NEAREST: take = !found || cand_dist < best_dist;
        default:      take = !found;
      endcase
    end
  end

  assign scan_end       = (scan_idx == call_total);
  assign stat.no_calls  = (call_total == '0);
  assign stat.scan_done = scan_end && found;
  assign stat.run_done  = (served_cnt == call_total);

  always_ff @(posedge clk) begin
    if (cmd.add_call && call_total != CNT_BITS'(MAX_CALLS))
      store[call_total[IDX_BITS-1:0]] <= FLOOR_BITS'(call_floor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      call_total   <= '0;
      car_floor    <= '0;
      served_marks <= '0;
      travel_sum   <= '0;
      served_cnt   <= '0;
      scan_idx     <= '0;
      found        <= 1'b0;
      scan_phase   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cmd.add_call && call_total != CNT_BITS'(MAX_CALLS))
        call_total <= call_total + 1'b1;
      if (cmd.run_init) begin
        served_marks <= '0;
        travel_sum   <= '0;
        served_cnt   <= '0;
        start_floor  <= car_floor;
      end
      if (cmd.scan_start) begin
        scan_idx   <= '0;
        found      <= 1'b0;
        scan_phase <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (scan_end) begin
          // Upward pass empty: restart downward.
          scan_idx   <= '0;
          scan_phase <= 1'b1;
        end else begin
          scan_idx <= scan_idx + 1'b1;
          if (take) begin
            found      <= 1'b1;
            best_idx   <= rd_idx;
            best_floor <= cur_floor;
          end
        end
      end
      if (cmd.serve) begin
        served_marks[best_idx] <= 1'b1;
        served_cnt   <= served_cnt + 1'b1;
        car_floor    <= best_floor;
        travel_sum   <= travel_sat;
        result_valid <= 1'b1;
        served_floor <= 8'(best_floor);
        direction    <= (best_floor > car_floor) ? DIR_UP :
                        (best_floor < car_floor) ? DIR_DOWN : DIR_STOP;
        is_last      <= (served_cnt + 1'b1 == call_total);
        empty_run    <= 1'b0;
        total_travel <= (served_cnt + 1'b1 == call_total) ? travel_sat : '0;
      end
      if (cmd.empty_out) begin
        result_valid <= 1'b1;
        served_floor <= 8'(car_floor);
        direction    <= DIR_STOP;
        total_travel <= '0;
        is_last      <= 1'b1;
        empty_run    <= 1'b1;
      end
    end
  end

  `FCS_ASSERT_IMP(a_total_bound, clk, rst, 1'b1, call_total <= CNT_BITS'(MAX_CALLS),
    "call count beyond store depth")
  `FCS_ASSERT_IMP(a_serve_found, clk, rst, cmd.serve, found,
    "serve without a chosen call")
  `FCS_ASSERT_NEXT(a_serve_marks, clk, rst, cmd.serve, served_marks[$past(best_idx)],
    "served call not marked")

endmodule

// File: rtl/fcs_ctrl.sv
// Controller of the floor call scheduler: sequences adds, searches and serves.
// Depends on fcs_pkg and the assertion macro header.
`include "floor_call_scheduler_top_defines.svh"

module fcs_ctrl import fcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      req_type,
  input  fcs_stat_t stat,
  output fcs_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_INIT  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_SERVE = 5'b01000,
    ST_EMPTY = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_ADD)
            cmd.add_call = 1'b1;
          else if (stat.no_calls)
            state_next = ST_EMPTY;
          else begin
            cmd.run_init = 1'b1;
            state_next   = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        // Finish once every stored call has been served.
        if (stat.run_done)
          state_next = ST_IDLE;
        else begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          cmd.scan_step = 1'b0;
          state_next    = ST_SERVE;
        end
      end
      ST_SERVE: begin
        cmd.serve = 1'b1;
        state_next = ST_INIT;
      end
      ST_EMPTY: begin
        cmd.empty_out = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  `FCS_ASSERT_IMP(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd), "more than one command")
  `FCS_ASSERT_NEXT(a_add_idle, clk, rst, cmd.add_call, state == ST_IDLE, "add left idle")

endmodule
